>>> design/assert_macros.svh
// Assertion macros used by the list buffer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define PLB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Condition must never be seen outside reset.
`define PLB_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

>>> design/plb_pkg.sv
// Types and codes shared by the positional list buffer modules.
package plb_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  // Cell index width, covers every capacity up to 256 plus the append slot.
  localparam int IDX_W    = 9;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
    logic             rd_en;
  } cell_cmd_t;

  typedef struct packed {
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } plb_rsp_t;

endpackage

>>> design/plb_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbors.
module plb_cell
  import plb_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INSERT: begin
        if (IDX == cmd.pos) begin
          data <= wdata;
        end else if (IDX > cmd.pos) begin
          data <= left_data;
        end
      end
      CELL_ERASE: begin
        // close the gap: take the right neighbor from the erased slot on
        if (IDX >= cmd.pos) begin
          data <= right_data;
        end
      end
      CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/plb_ctrl.sv
// Operation decode, bounds checks, entry count and result registers.
`include "assert_macros.svh"

module plb_ctrl
  import plb_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   operation,
  input  logic [POS_W-1:0]  position,
  output cell_cmd_t         cmd,
  output plb_rsp_t          rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic [STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]    pos_ext;
  logic [IDX_W-1:0]    cnt_ext;
  logic                full;
  logic                empty;

  assign pos_ext = IDX_W'(position);
  assign cnt_ext = IDX_W'(cnt);
  assign full    = cnt_ext >= IDX_W'(CAPACITY);
  assign empty   = cnt == '0;

  always_comb begin
    cmd         = '{op: CELL_HOLD, pos: pos_ext, rd_en: 1'b0};
    status_next = ST_OK;
    cnt_next    = cnt;
    if (start) begin
      unique case (operation)
        OP_APPEND: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            cmd.op   = CELL_INSERT;
            cmd.pos  = cnt_ext;
            cnt_next = cnt + 1'b1;
          end
        end
        OP_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            status_next = ST_BADPOS;
          end else begin
            cmd.op   = CELL_INSERT;
            cnt_next = cnt + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            cnt_next = cnt - 1'b1;
          end
        end
        OP_ERASE: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            status_next = ST_BADPOS;
          end else begin
            cmd.op   = CELL_ERASE;
            cnt_next = cnt - 1'b1;
          end
        end
        OP_CLEAR: begin
          cnt_next = '0;
        end
        OP_READ: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            status_next = ST_BADPOS;
          end else begin
            cmd.rd_en = 1'b1;
          end
        end
        default: begin
          // unused codes: report ok, change nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rsp <= '0;
    end else begin
      cnt          <= cnt_next;
      rsp.done     <= start;
      rsp.status   <= status_next;
      rsp.count    <= COUNT_W'(cnt_next);
      rsp.is_empty <= cnt_next == '0;
    end
  end

  `PLB_ASSERT(a_done_follows_start, start |=> rsp.done)
  `PLB_NEVER(a_count_in_range, cnt > CNT_W'(CAPACITY))
  `PLB_ASSERT(a_error_keeps_count, (start && status_next != ST_OK) |=> cnt == $past(cnt))
  `PLB_NEVER(a_cells_idle_without_request, !start && cmd.op != CELL_HOLD)

endmodule

>>> design/positional_list_buffer.sv
// Positional list buffer: a fixed-capacity ordered list built as a row of cells.
// Every operation (append, insert, remove last, erase, clear, read) is taken on
// any edge with start high, busy stays low, and the result (read data, count,
// empty flag, status) appears on the next cycle with done high for exactly one
// cycle, so a request can follow every cycle. The rate is set by the cell row:
// each cell compares its own index with the target position and loads from its
// left or right neighbor in the same edge. The receiver cannot stall; it must
// take each result in the cycle done is high.
// Failed operations (full, bad position, empty list) leave the list unchanged.
module positional_list_buffer
  import plb_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation,
  input  logic [POS_W-1:0]    position,
  input  logic [VALUE_W-1:0]  value,
  output logic                done,
  output logic [VALUE_W-1:0]  read_data,
  output logic [COUNT_W-1:0]  count,
  output logic                is_empty,
  output logic [STATUS_W-1:0] status
);

  localparam int RD_W = $clog2(CAPACITY);

  cell_cmd_t             cmd;
  plb_rsp_t              rsp;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
  logic [DATA_WIDTH-1:0] left_data  [CAPACITY];
  logic [DATA_WIDTH-1:0] right_data [CAPACITY];
  logic [RD_W-1:0]       rd_idx;

  assign busy   = 1'b0;
  assign wdata  = DATA_WIDTH'(value);
  assign rd_idx = RD_W'(position);

  plb_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .position  (position),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_data[i] = wdata;
    end else begin : g_inner_l
      assign left_data[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data[i] = cell_data[i];
    end else begin : g_inner_r
      assign right_data[i] = cell_data[i+1];
    end

    plb_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .wdata      (wdata),
      .left_data  (left_data[i]),
      .right_data (right_data[i]),
      .data       (cell_data[i])
    );
  end

  // zero unless a checked read hits a valid entry
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      read_data <= VALUE_W'(cell_data[rd_idx]);
    end else begin
      read_data <= '0;
    end
  end

  assign done     = rsp.done;
  assign count    = rsp.count;
  assign is_empty = rsp.is_empty;
  assign status   = rsp.status;

endmodule

>>> bench/tb_positional_list_buffer.sv
`timescale 1ns / 100ps
// Testbench for positional_list_buffer: directed and random list requests checked per reply.
module tb_positional_list_buffer;
  import plb_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int LIST_DEPTH   = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 4;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_data;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } list_reply_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OP_W-1:0]     operation = '0;
  logic [POS_W-1:0]    position = '0;
  logic [VALUE_W-1:0]  value = '0;
  logic                busy;
  logic                done;
  logic [VALUE_W-1:0]  read_data;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;
  logic [STATUS_W-1:0] status;

  // Software copy of the list, advanced on every accepted request
  logic [VALUE_W-1:0] list_vals [LIST_DEPTH];
  int                 list_len = 0;
  int                 peak_len = 0;
  list_reply_t        replies_due [$];

  int  mismatches = 0;
  int  cycles = 0;
  int  requests_sent = 0;
  int  replies_checked = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  bit  sender_idles = 1'b1;

  positional_list_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .position  (position),
    .value     (value),
    .done      (done),
    .read_data (read_data),
    .count     (count),
    .is_empty  (is_empty),
    .status    (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, replies_due.size());
      $display("** positional_list_buffer: FAILED **");
      $finish;
    end
  end

  function automatic list_reply_t apply_list_op(input logic [OP_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VALUE_W-1:0] val);
    list_reply_t r;
    r.read_data = '0;
    r.status    = ST_OK;
    case (op)
      OP_APPEND: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          list_vals[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        // full is checked before the position
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else if (pos > list_len) r.status = ST_BADPOS;
        else begin
          for (int k = list_len; k > pos; k--) list_vals[k] = list_vals[k-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      OP_ERASE: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (pos >= list_len) r.status = ST_BADPOS;
        else begin
          for (int k = pos; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
          list_len--;
        end
      end
      OP_CLEAR: list_len = 0;
      OP_READ: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (pos >= list_len) r.status = ST_BADPOS;
        else r.read_data = list_vals[pos];
      end
      default: ;
    endcase
    r.count    = list_len[COUNT_W-1:0];
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
    mismatches++;
  endtask

  // Called and returns at a rising edge; start stays high across back-to-back requests.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val);
    bit taken;
    if (sender_idles && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    replies_due = {replies_due, apply_list_op(op, pos, val)};
    requests_sent++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    // advance at least one edge so start is not driven twice in one step
    @(posedge clk);
  endtask

  task automatic send_random(input op_mix_t mix);
    int r;
    int w_app, w_ins, w_rd, w_era;
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    case (mix)
      MIX_GROW:   begin w_app = 40; w_ins = 30; w_rd = 15; w_era = 7;  end
      MIX_SHRINK: begin w_app = 8;  w_ins = 8;  w_rd = 16; w_era = 40; end
      default:    begin w_app = 20; w_ins = 20; w_rd = 25; w_era = 17; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_app) op = OP_APPEND;
    else if (r < w_app + w_ins) op = OP_INSERT;
    else if (r < w_app + w_ins + w_rd) op = OP_READ;
    else if (r < w_app + w_ins + w_rd + w_era) op = OP_ERASE;
    else if (r < 97) op = OP_REMOVE;
    else if (r == 97) op = OP_CLEAR;
    else if (r == 98) op = OP_SPARE_6;
    else op = OP_SPARE_7;
    // mostly positions inside or just past the list, sometimes anything
    if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 31));
    else pos = POS_W'($urandom_range(0, list_len));
    r = $urandom_range(0, 15);
    if (r == 0) val = '0;
    else if (r == 1) val = '1;
    else val = $urandom;
    send_request(op, pos, val);
  endtask

  task automatic test_empty_list();
    send_request(OP_READ,    5'd0,  32'h0);
    send_request(OP_READ,    5'd31, 32'hFFFF_FFFF);
    send_request(OP_REMOVE,  5'd0,  32'h0);
    send_request(OP_ERASE,   5'd0,  32'h0);
    send_request(OP_ERASE,   5'd31, 32'h0);
    send_request(OP_INSERT,  5'd1,  32'h1234_5678);
    send_request(OP_SPARE_6, 5'd0,  32'hFFFF_FFFF);
    send_request(OP_SPARE_7, 5'd31, 32'h0);
    send_request(OP_CLEAR,   5'd0,  32'h0);
  endtask

  task automatic test_basic_ops();
    send_request(OP_INSERT,  5'd0,  32'hFFFF_FFFF);
    send_request(OP_APPEND,  5'd31, 32'h0000_0000);
    send_request(OP_APPEND,  5'd0,  32'hA5A5_A5A5);
    send_request(OP_INSERT,  5'd3,  32'h0BAD_F00D);
    send_request(OP_INSERT,  5'd5,  32'hDEAD_BEEF);
    send_request(OP_INSERT,  5'd1,  32'h5A5A_5A5A);
    send_request(OP_READ,    5'd0,  32'h0);
    send_request(OP_READ,    5'd4,  32'h0);
    send_request(OP_READ,    5'd5,  32'h0);
    send_request(OP_READ,    5'd31, 32'h0);
    send_request(OP_ERASE,   5'd31, 32'h0);
    send_request(OP_ERASE,   5'd0,  32'h0);
    send_request(OP_ERASE,   5'd3,  32'h0);
    send_request(OP_REMOVE,  5'd0,  32'h0);
    send_request(OP_SPARE_6, 5'd31, 32'hFFFF_FFFF);
    send_request(OP_READ,    5'd1,  32'h0);
    send_request(OP_CLEAR,   5'd0,  32'h0);
    send_request(OP_READ,    5'd0,  32'h0);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_DEPTH) begin
      if ($urandom_range(0, 1)) send_request(OP_APPEND, POS_W'($urandom_range(0, 31)), $urandom);
      else send_request(OP_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
    end
    send_request(OP_APPEND, 5'd0,  32'hFFFF_FFFF);
    send_request(OP_INSERT, 5'd0,  32'h1111_1111);
    send_request(OP_INSERT, 5'd31, 32'h2222_2222);
    for (int i = 0; i <= LIST_DEPTH; i++) send_request(OP_READ, POS_W'(i), 32'h0);
    send_request(OP_ERASE, POS_W'(LIST_DEPTH), 32'h0);
    send_request(OP_ERASE, POS_W'(LIST_DEPTH - 1), 32'h0);
    while (list_len > 0) begin
      if ($urandom_range(0, 1)) send_request(OP_REMOVE, 5'd0, 32'h0);
      else send_request(OP_ERASE, POS_W'($urandom_range(0, list_len - 1)), 32'h0);
    end
  endtask

  task automatic test_random_mix(input int n);
    op_mix_t mix;
    mix = MIX_EVEN;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) mix = op_mix_t'($urandom_range(0, 2));
      send_random(mix);
    end
  endtask

  task automatic test_steady_stream(input int n);
    sender_idles = 1'b0;
    test_random_mix(n);
    sender_idles = 1'b1;
  endtask

  task automatic test_pause_for_replies(input int rounds, input int per_round);
    for (int i = 0; i < rounds; i++) begin
      test_random_mix(per_round);
      wait_for_replies();
    end
  endtask

  always @(negedge clk) begin : check_reply
    list_reply_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected reply (read_data)", read_data, '0);
      end else begin
        want = replies_due.pop_front();
        if (read_data !== want.read_data) report_mismatch("read_data", read_data, want.read_data);
        if (count !== want.count)
          report_mismatch("count", VALUE_W'(count), VALUE_W'(want.count));
        if (is_empty !== want.is_empty)
          report_mismatch("is_empty", VALUE_W'(is_empty), VALUE_W'(want.is_empty));
        if (status !== want.status)
          report_mismatch("status", VALUE_W'(status), VALUE_W'(want.status));
        status_seen[want.status]++;
        replies_checked++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_mix(1100);
    test_steady_stream(400);
    test_pause_for_replies(6, 40);
    wait_for_replies();
    repeat (SETTLE_TICKS) @(posedge clk);
    $display("ran %0d requests, %0d replies checked, list grew to %0d entries",
             requests_sent, replies_checked, peak_len);
    $display("statuses seen: ok %0d, full %0d, bad position %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
             status_seen[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("** positional_list_buffer: PASSED **");
    end else begin
      $display("** positional_list_buffer: FAILED **");
    end
    $finish;
  end

endmodule

>>> positional_list_buffer.f
+incdir+design
design/plb_pkg.sv
design/plb_cell.sv
design/plb_ctrl.sv
design/positional_list_buffer.sv
bench/tb_positional_list_buffer.sv
